@@ hw/rtl/srwa_pkg.sv @@
package srwa_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CHAN_W   = 4;
	localparam int WIN_W    = 4;

	localparam int CHANNELS_DEF   = 10;
	localparam int MAX_WINDOW_DEF = 8;

	// longest window the 4-bit register can ask for
	localparam int WIN_MAX = (2 ** WIN_W) - 1;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);
	localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(3);

	// two samples are dropped from every window
	localparam logic [WIN_W-1:0] WIN_DROP  = WIN_W'(2);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} srwa_state_t;

endpackage

@@ hw/rtl/spike_rejecting_window_average.sv @@
// Spike-rejecting window average. Each item carries a 10-bit sample and its
// channel; the sample goes into that channel's ring of recent samples, then
// the first window_length entries of the ring are summed, the largest and
// smallest are dropped and the rest is divided by window_length - 2
// (truncated). One result per item whose channel is below CHANNELS; items
// on other channels are taken and dropped without any effect. One item is
// worked at a time, through a walk over the ring (one read a cycle) and
// the 10-step serial divider. The next item is taken as soon as the result
// sits in the output register, even while it is stalled. After reset the
// history memory is cleared one entry a cycle, all CHANNELS * MAX_WINDOW
// entries, with sample_stall high; window_length writes are taken during
// that time. window_length below 3 acts as 3, above MAX_WINDOW as MAX_WINDOW.
module spike_rejecting_window_average #(
	parameter int CHANNELS   = srwa_pkg::CHANNELS_DEF,
	parameter int MAX_WINDOW = srwa_pkg::MAX_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          window_length_we,
	input  logic [srwa_pkg::WIN_W-1:0]    window_length,
	// input items
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [srwa_pkg::CHAN_W-1:0]   channel,
	input  logic [srwa_pkg::SAMPLE_W-1:0] sample,
	// result items
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [srwa_pkg::CHAN_W-1:0]   out_channel,
	output logic [srwa_pkg::SAMPLE_W-1:0] filtered_value
);

	localparam int SW      = srwa_pkg::SAMPLE_W;
	localparam int CW      = srwa_pkg::CHAN_W;
	localparam int WW      = srwa_pkg::WIN_W;
	localparam int MAX_LEN = (MAX_WINDOW < srwa_pkg::WIN_MAX) ? MAX_WINDOW : srwa_pkg::WIN_MAX;
	localparam int DEPTH   = CHANNELS * MAX_WINDOW;
	localparam int AW      = $clog2(DEPTH);
	localparam int CIW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW      = $clog2(MAX_LEN);
	localparam int SUM_W   = $clog2(MAX_LEN * (2 ** SW));

	srwa_pkg::srwa_state_t state_q, state_d;

	// configuration and latched item
	logic [WW-1:0]  win_len_q;
	logic [WW-1:0]  len_q;
	logic [CW-1:0]  chan_q;
	logic [SW-1:0]  smp_q;

	// per-channel write position, below the window in use when it was written
	logic [PW-1:0]  wp_q [CHANNELS];

	logic [AW-1:0]  clr_addr_q;
	logic [WW-1:0]  rd_cnt_q;
	logic           rd_vld_s1;
	logic           rd_first_s1;

	// running sum, max and min over the window
	logic [SUM_W-1:0] sum_q;
	logic [SW-1:0]    hi_q;
	logic [SW-1:0]    lo_q;

	logic          result_valid_q;
	logic [CW-1:0] out_channel_q;
	logic [SW-1:0] filtered_value_q;

	logic          accept;
	logic          chan_ok;
	logic [WW-1:0] eff_len;
	logic [WW-1:0] wp_cur;
	logic [WW-1:0] pos;
	logic [WW-1:0] pos_next;
	logic [AW-1:0] base_addr;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [SW-1:0] mem_rdata;

	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] dividend;
	logic [SW-1:0]    quotient;
	logic             load_result;
	logic             result_taken;

	// window length saturated to the legal range
	always_comb begin
		eff_len = win_len_q;
		if (win_len_q < srwa_pkg::WIN_MIN) begin
			eff_len = srwa_pkg::WIN_MIN;
		end else if (win_len_q > WW'(MAX_LEN)) begin
			eff_len = WW'(MAX_LEN);
		end
	end

	assign chan_ok = {1'b0, channel} < (CW + 1)'(CHANNELS);
	assign accept  = sample_valid && !sample_stall;

	// ring position: a position left over from a longer window restarts at 0
	assign wp_cur    = WW'(wp_q[chan_q[CIW-1:0]]);
	assign pos       = (wp_cur >= len_q) ? '0 : wp_cur;
	assign pos_next  = (pos == len_q - WW'(1)) ? '0 : pos + WW'(1);
	assign base_addr = AW'(chan_q) * AW'(MAX_WINDOW);

	assign dividend     = sum_q - SUM_W'(hi_q) - SUM_W'(lo_q);
	assign result_taken = result_valid_q && !result_stall;

	// sequencer: next state and datapath controls
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		mem_we       = 1'b0;
		mem_waddr    = base_addr + AW'(pos);
		mem_wdata    = smp_q;
		mem_raddr    = base_addr + AW'(rd_cnt_q);
		div_start    = 1'b0;
		load_result  = 1'b0;
		case (state_q)
			srwa_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = srwa_pkg::ST_IDLE;
				end
			end
			srwa_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid && chan_ok) begin
					state_d = srwa_pkg::ST_WRITE;
				end
			end
			srwa_pkg::ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = srwa_pkg::ST_READ;
			end
			srwa_pkg::ST_READ: begin
				if (rd_cnt_q == len_q - WW'(1)) begin
					state_d = srwa_pkg::ST_DRAIN;
				end
			end
			srwa_pkg::ST_DRAIN: begin
				// last read data lands in the accumulator here
				state_d = srwa_pkg::ST_DIV_START;
			end
			srwa_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = srwa_pkg::ST_DIV_WAIT;
			end
			srwa_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = srwa_pkg::ST_OUT;
				end
			end
			srwa_pkg::ST_OUT: begin
				// wait for the output register to free up
				if (!result_valid_q || !result_stall) begin
					load_result = 1'b1;
					state_d     = srwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srwa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srwa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= srwa_pkg::WIN_RESET;
		end else if (window_length_we) begin
			win_len_q <= window_length;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == srwa_pkg::ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i] <= '0;
			end
		end else if (state_q == srwa_pkg::ST_WRITE) begin
			wp_q[chan_q[CIW-1:0]] <= pos_next[PW-1:0];
		end
	end

	// latch the item on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q <= channel;
			smp_q  <= sample;
			len_q  <= eff_len;
		end
	end

	// window walk: one read issued a cycle, its data in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_vld_s1   <= state_q == srwa_pkg::ST_READ;
			rd_first_s1 <= (state_q == srwa_pkg::ST_READ) && (rd_cnt_q == '0);
			if (state_q == srwa_pkg::ST_READ) begin
				rd_cnt_q <= rd_cnt_q + WW'(1);
			end else begin
				rd_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				sum_q <= SUM_W'(mem_rdata);
				hi_q  <= mem_rdata;
				lo_q  <= mem_rdata;
			end else begin
				sum_q <= sum_q + SUM_W'(mem_rdata);
				if (mem_rdata > hi_q) begin
					hi_q <= mem_rdata;
				end
				if (mem_rdata < lo_q) begin
					lo_q <= mem_rdata;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_taken) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			out_channel_q    <= chan_q;
			filtered_value_q <= quotient;
		end
	end

	srwa_hist_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_hist_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	srwa_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (len_q - srwa_pkg::WIN_DROP),
		.done     (div_done),
		.quotient (quotient)
	);

	assign result_valid   = result_valid_q;
	assign out_channel    = out_channel_q;
	assign filtered_value = filtered_value_q;

endmodule

@@ hw/rtl/srwa_hist_mem.sv @@
module srwa_hist_mem #(
	parameter int DEPTH = srwa_pkg::CHANNELS_DEF * srwa_pkg::MAX_WINDOW_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [srwa_pkg::SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [srwa_pkg::SAMPLE_W-1:0] rdata
);

	logic [srwa_pkg::SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/srwa_div.sv @@
module srwa_div #(
	parameter int SUM_W = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SUM_W-1:0]              dividend,
	input  logic [srwa_pkg::WIN_W-1:0]    divisor,
	output logic                          done,
	output logic [srwa_pkg::SAMPLE_W-1:0] quotient
);

	localparam int QW    = srwa_pkg::SAMPLE_W;
	localparam int WW    = srwa_pkg::WIN_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WW-1:0]    rem_q;
	logic [WW-1:0]    div_q;
	logic [QW-1:0]    quo_q;

	logic [WW:0]      trial;
	logic             ge;
	logic [WW-1:0]    rem_d;

	// restoring step: quotient fits in QW bits, so the upper dividend bits
	// already sit below the divisor and only QW steps are needed
	assign trial = {rem_q, quo_q[QW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign rem_d = ge ? WW'(trial - {1'b0, div_q}) : trial[WW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= WW'(dividend >> QW);
			quo_q <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/srwa_checker.sv @@
module srwa_checker #(
	parameter int CHANNELS = srwa_pkg::CHANNELS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic [srwa_pkg::CHAN_W-1:0]   channel,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [srwa_pkg::CHAN_W-1:0]   out_channel,
	input logic [srwa_pkg::SAMPLE_W-1:0] filtered_value
);

	logic take_item;

	assign take_item = sample_valid && !sample_stall &&
		({1'b0, channel} < (srwa_pkg::CHAN_W + 1)'(CHANNELS));

	// an item on a live channel keeps the block busy
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		take_item |=> sample_stall)
		else $error("block took a second item right after a live one");

	// no result can show up the cycle after an item is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_item |=> !$rose(result_valid))
		else $error("result appeared too soon after an item");

	// results only name channels that exist
	a_result_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, out_channel} < (srwa_pkg::CHAN_W + 1)'(CHANNELS)))
		else $error("result on a channel out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(out_channel) && $stable(filtered_value))
		else $error("stalled result changed");

endmodule

bind spike_rejecting_window_average srwa_checker #(.CHANNELS(CHANNELS)) u_srwa_checker (.*);
